// ===== rtl/nscb64_pkg.sv =====
`timescale 1ns / 1ps
package nscb64_pkg;

   // run status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
   localparam logic [1:0] ST_TOO_SHORT  = 2'd2;
   localparam logic [1:0] ST_BAD_CHAR   = 2'd3;

   // prefix characters and the two symbol characters
   localparam logic [7:0] CH_PREFIX0 = 8'h30;
   localparam logic [7:0] CH_PREFIX1 = 8'h32;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   localparam logic [5:0] SX_LBRACE = 6'd62;
   localparam logic [5:0] SX_RBRACE = 6'd63;

   // results caused by one input beat
   typedef struct packed {
      logic        has_data;
      logic [23:0] word;
      logic        has_status;
      logic [1:0]  status;
   } bundle_type;

   // {valid, sextet}
   function automatic logic [6:0] sextet_map(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd36)};
      end else if (c == CH_LBRACE) begin
         r = {1'b1, SX_LBRACE};
      end else if (c == CH_RBRACE) begin
         r = {1'b1, SX_RBRACE};
      end
      return r;
   endfunction

endpackage

// ===== rtl/nscb64_step.sv =====
`timescale 1ns / 1ps
module nscb64_step #(
   parameter int HEADER_SKIP = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              char_code,
   input  logic                    end_of_string,
   output nscb64_pkg::bundle_type  bundle,
   output logic                    push
);
   import nscb64_pkg::*;

   localparam int HdrW = $clog2(HEADER_SKIP + 3);
   localparam logic [HdrW-1:0] HdrEnd = HdrW'(HEADER_SKIP + 2);

   logic [HdrW-1:0] hdr_ff, hdr_in;
   logic [1:0]      phase_ff, phase_in;
   logic [17:0]     acc_ff, acc_in;
   logic            seen_ff, seen_in;
   logic            pbad_ff, pbad_in;
   logic [1:0]      err_ff, err_in;
   logic [6:0]      mapped;
   logic            pbad_next;

   assign mapped = sextet_map(char_code);

   always_comb begin
      hdr_in    = hdr_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      seen_in   = seen_ff;
      pbad_in   = pbad_ff;
      err_in    = err_ff;
      pbad_next = pbad_ff | ~mapped[6];
      bundle    = '0;

      if (err_ff == ST_OK) begin
         if (hdr_ff == HdrW'(0)) begin
            if (char_code != CH_PREFIX0) err_in = ST_BAD_PREFIX;
            hdr_in = HdrW'(1);
         end else if (hdr_ff == HdrW'(1)) begin
            if (char_code != CH_PREFIX1) err_in = ST_BAD_PREFIX;
            hdr_in = HdrW'(2);
         end else if (hdr_ff < HdrEnd) begin
            hdr_in = hdr_ff + HdrW'(1);
         end else if (phase_ff != 2'd3) begin
            acc_in   = {acc_ff[11:0], mapped[5:0]};
            phase_in = phase_ff + 2'd1;
            pbad_in  = pbad_next;
         end else begin
            if (pbad_next) begin
               err_in = ST_BAD_CHAR;
            end else begin
               bundle.has_data = 1'b1;
               bundle.word     = {acc_ff, mapped[5:0]};
               seen_in         = 1'b1;
            end
            phase_in = 2'd0;
            acc_in   = '0;
            pbad_in  = 1'b0;
         end
      end

      if (end_of_string) begin
         bundle.has_status = 1'b1;
         bundle.status     = err_in;
         if (err_in == ST_OK) begin
            if (hdr_in < HdrW'(2))  bundle.status = ST_BAD_PREFIX;
            else if (!seen_in)      bundle.status = ST_TOO_SHORT;
         end
         // string closed, back to the reset state
         hdr_in   = '0;
         phase_in = 2'd0;
         acc_in   = '0;
         seen_in  = 1'b0;
         pbad_in  = 1'b0;
         err_in   = ST_OK;
      end
   end

   assign push = accept & (bundle.has_data | bundle.has_status);

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff   <= '0;
         phase_ff <= 2'd0;
         acc_ff   <= '0;
         seen_ff  <= 1'b0;
         pbad_ff  <= 1'b0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         hdr_ff   <= hdr_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         seen_ff  <= seen_in;
         pbad_ff  <= pbad_in;
         err_ff   <= err_in;
      end
   end

endmodule

// ===== rtl/nsc_base64_decoder.sv =====
`timescale 1ns / 1ps
// result path: an accepted input beat writes its bundle into the queue, offered when at the head
// throughput: one character per cycle unless stalled; each good four-character group yields three byte beats
// and the closing character one status beat, drained one per cycle from a two-entry queue
// input stalls while two bundles wait: a consumer stall, or a status close behind a group
// reset: synchronous, active high; clears decoder state and the result queue
module nsc_base64_decoder #(
   parameter int HEADER_SKIP = 12
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_string
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [2:0] rsp_tuser,   // [0] is_status, [2:1] status
   output logic       rsp_tlast    // last_of_run
);
   import nscb64_pkg::*;

   logic       accept;
   logic       push;
   bundle_type bundle;

   // decoder state and per-character logic
   nscb64_step #(
      .HEADER_SKIP (HEADER_SKIP)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .char_code     (req_tdata),
      .end_of_string (req_tlast),
      .bundle        (bundle),
      .push          (push)
   );

   // two-entry queue of result bundles, so input keeps flowing while a bundle drains
   bundle_type ent_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] idx_ff, idx_in;   // byte position inside the head bundle, 3 = status
   bundle_type head;
   logic       in_data;
   logic       beat;
   logic       pop;

   assign req_tready = (cnt_ff != 2'd2);
   assign accept     = req_tvalid & req_tready;

   assign head       = ent_ff[rd_ptr_ff];
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign in_data    = head.has_data & (idx_ff != 2'd3);
   assign beat       = rsp_tvalid & rsp_tready;
   // head bundle is done after its last byte when no status follows, or after its status
   assign pop        = beat & (~in_data | ((idx_ff == 2'd2) & ~head.has_status));

   always_comb begin
      rsp_tdata = 8'd0;
      if (in_data) begin
         case (idx_ff)
            2'd0:    rsp_tdata = head.word[23:16];
            2'd1:    rsp_tdata = head.word[15:8];
            2'd2:    rsp_tdata = head.word[7:0];
            default: rsp_tdata = 8'd0;
         endcase
      end
   end

   assign rsp_tuser = in_data ? 3'd0 : {head.status, 1'b1};
   assign rsp_tlast = ~in_data;

   always_comb begin
      idx_in = idx_ff;
      if (beat) idx_in = pop ? 2'd0 : idx_ff + 2'd1;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
         idx_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // bundle payload, no reset needed
   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ptr_ff] <= bundle;
   end

`ifndef SYNTHESIS
   // queue never holds more than two bundles
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("result queue count out of range");

   // a status beat only comes from a bundle that carries a status
   a_status_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> head.has_status)
      else $error("status beat without status in bundle");

   // byte index only advances past zero inside a data bundle
   a_idx_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && idx_ff != 2'd0) |-> head.has_data)
      else $error("byte index set on status-only bundle");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("result offered after reset");
`endif

endmodule

// ===== tb/decode_checker.sv =====
`timescale 1ns / 1ps
module decode_checker #(
   parameter int HDR_SKIP = 12
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_string
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] data_byte
   input  logic [2:0] rsp_tuser,   // [0] is_status, [2:1] status
   input  logic       rsp_tlast,   // last_of_run
   output int         fail_count,
   output int         pending,
   output int         data_beats,
   output int         status_beats
);
   import nscb64_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_status;
      logic [1:0] status;
      logic       last_of_run;
   } result_beat_type;

   result_beat_type expected_beats[$];

   // decoder state as predicted
   int          hdr_count = 0;
   int          quad_phase = 0;
   logic [17:0] sextets = '0;
   logic        quad_done = 1'b0;
   logic        quad_tainted = 1'b0;
   logic [1:0]  run_err = ST_OK;
   int          errs = 0;

   assign fail_count = errs;

   task automatic clear_run();
      hdr_count = 0;
      quad_phase = 0;
      sextets = '0;
      quad_done = 1'b0;
      quad_tainted = 1'b0;
      run_err = ST_OK;
   endtask

   function automatic result_beat_type byte_beat(input logic [7:0] b);
      return '{b, 1'b0, ST_OK, 1'b0};
   endfunction

   task automatic take_char(input logic [7:0] c, input logic eos);
      logic [5:0]  v;
      logic        ok;
      logic [23:0] w;
      ok = 1'b1;
      v = '0;
      if (c >= "0" && c <= "9") begin
         v = 6'(c - "0");
      end else if (c >= "A" && c <= "Z") begin
         v = 6'(c - "A" + 8'd10);
      end else if (c >= "a" && c <= "z") begin
         v = 6'(c - "a" + 8'd36);
      end else if (c == CH_LBRACE) begin
         v = SX_LBRACE;
      end else if (c == CH_RBRACE) begin
         v = SX_RBRACE;
      end else begin
         ok = 1'b0;
      end

      if (run_err == ST_OK) begin
         if (hdr_count == 0) begin
            if (c != CH_PREFIX0) run_err = ST_BAD_PREFIX;
            hdr_count = 1;
         end else if (hdr_count == 1) begin
            if (c != CH_PREFIX1) run_err = ST_BAD_PREFIX;
            hdr_count = 2;
         end else if (hdr_count < 2 + HDR_SKIP) begin
            hdr_count++;
         end else begin
            if (!ok) quad_tainted = 1'b1;
            if (quad_phase < 3) begin
               sextets = {sextets[11:0], v};
               quad_phase++;
            end else begin
               if (quad_tainted) begin
                  run_err = ST_BAD_CHAR;
               end else begin
                  w = {sextets, v};
                  expected_beats.push_back(byte_beat(w[23:16]));
                  expected_beats.push_back(byte_beat(w[15:8]));
                  expected_beats.push_back(byte_beat(w[7:0]));
                  quad_done = 1'b1;
               end
               quad_phase = 0;
               sextets = '0;
               quad_tainted = 1'b0;
            end
         end
      end

      if (eos) begin
         if (run_err == ST_OK) begin
            if (hdr_count < 2) run_err = ST_BAD_PREFIX;
            else if (!quad_done) run_err = ST_TOO_SHORT;
         end
         expected_beats.push_back('{8'd0, 1'b1, run_err, 1'b1});
         clear_run();
      end
   endtask

   always @(posedge clock) begin
      result_beat_type got;
      result_beat_type want;
      if (reset) begin
         clear_run();
         expected_beats.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata, rsp_tuser[0], rsp_tuser[2:1], rsp_tlast};
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: data_byte %0h tuser %0h last_of_run %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               errs++;
            end else begin
               want = expected_beats.pop_front();
               if (got.data_byte != want.data_byte) begin
                  $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                  errs++;
               end
               if (got.is_status != want.is_status) begin
                  $error("is_status: expected %0b, got %0b", want.is_status, got.is_status);
                  errs++;
               end
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  errs++;
               end
               if (got.last_of_run != want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b",
                         want.last_of_run, got.last_of_run);
                  errs++;
               end
               if (want.is_status) status_beats++;
               else data_beats++;
            end
         end
         if (req_tvalid && req_tready) take_char(req_tdata, req_tlast);
      end
      pending <= expected_beats.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import nscb64_pkg::*;

   localparam int HDR_SKIP    = 12;
   localparam int RAND_ITEMS  = 320;
   localparam int HOLD_CYCLES = 60;
   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;

   // input channel
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] char_code
   logic       req_tlast = 1'b0;   // end_of_string

   // result channel
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [7:0] data_byte
   logic [2:0] rsp_tuser;          // [0] is_status, [2:1] status
   logic       rsp_tlast;          // last_of_run

   int fail_count;
   int pending;
   int data_beats;
   int status_beats;

   // stimulus bookkeeping
   logic [7:0] str_buf[$];
   int         items_sent = 0;
   int         strings_sent = 0;
   int         cycles = 0;
   bit         tx_calm = 1'b0;
   bit         rx_calm = 1'b0;
   int         hold_orders = 0;
   int         holds_served = 0;
   int         hold_left = 0;

   nsc_base64_decoder #(
      .HEADER_SKIP(HDR_SKIP)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   decode_checker #(
      .HDR_SKIP(HDR_SKIP)
   ) chk (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast),
      .fail_count   (fail_count),
      .pending      (pending),
      .data_beats   (data_beats),
      .status_beats (status_beats)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still expected", cycles, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: random back-pressure, calm stretches, and long hold-offs on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_orders) begin
         holds_served <= holds_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !reset && (rx_calm || $urandom_range(99) >= 16);
      end
   end

   // six-bit value to its character
   function automatic logic [7:0] sym_char(input int unsigned v);
      if (v < 10) return 8'("0" + v);
      if (v < 36) return 8'("A" + v - 10);
      if (v < 62) return 8'("a" + v - 36);
      if (v == 62) return CH_LBRACE;
      return CH_RBRACE;
   endfunction

   // any nonzero character outside the alphabet
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(1, 255));
      end while ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                 (c >= "a" && c <= "z") || c == CH_LBRACE || c == CH_RBRACE);
      return c;
   endfunction

   // good prefix plus the skipped header; fill of zero means random header chars
   task automatic fill_header(input logic [7:0] fill);
      str_buf.delete();
      str_buf.push_back(CH_PREFIX0);
      str_buf.push_back(CH_PREFIX1);
      repeat (HDR_SKIP) begin
         str_buf.push_back(fill != 8'd0 ? fill : 8'($urandom_range(1, 255)));
      end
   endtask

   // offer one character, with an occasional gap in front, and wait for the handshake
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      if (!tx_calm && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 4);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // whole string, end_of_string on its final character
   task automatic send_buf();
      foreach (str_buf[i]) send_char(str_buf[i], i == str_buf.size() - 1);
      strings_sent++;
   endtask

   initial begin
      int kind;
      int n;
      int nstr;
      int rand_goal;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: string that ends on its first character
      str_buf = '{CH_PREFIX0};
      send_buf();
      // wrong first prefix character
      str_buf = '{8'h31, CH_PREFIX1};
      send_buf();
      // wrong second prefix character
      str_buf = '{CH_PREFIX0, 8'h33};
      send_buf();
      // good prefix and nothing else: too short
      str_buf = '{CH_PREFIX0, CH_PREFIX1};
      send_buf();
      // zero byte inside the first group: bad character
      fill_header(8'hFF);
      str_buf.push_back("A");
      str_buf.push_back(8'h00);
      str_buf.push_back("z");
      str_buf.push_back("9");
      send_buf();
      // all-ones group, brace group, then a dropped trailing partial group
      fill_header(8'h01);
      repeat (4) str_buf.push_back(CH_RBRACE);
      str_buf.push_back(CH_LBRACE);
      str_buf.push_back("z");
      str_buf.push_back("A");
      str_buf.push_back("0");
      str_buf.push_back(8'hFF);
      send_buf();

      // random strings, mostly well formed, up to the total item count
      rand_goal = RAND_ITEMS;
      nstr = 0;
      while (items_sent < rand_goal) begin
         tx_calm = (nstr == 3) || (nstr >= 4 && nstr < 9);
         rx_calm = (nstr >= 4 && nstr < 9);
         // long receiver hold-off while the sender keeps streaming
         if (nstr == 3) hold_orders++;
         // sender pause until the decoder has drained
         if (nstr == 6) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end

         kind = (nstr == 3) ? 0 : $urandom_range(99);
         if (kind < 70) begin
            fill_header(8'd0);
            n = (nstr == 3) ? 24 : $urandom_range(0, 17);
            repeat (n) begin
               str_buf.push_back($urandom_range(99) < 4 ? junk_char()
                                                        : sym_char($urandom_range(63)));
            end
         end else if (kind < 80) begin
            // broken prefix, random tail
            str_buf.delete();
            n = $urandom_range(1, 20);
            repeat (n) str_buf.push_back(8'($urandom_range(1, 255)));
            if ($urandom_range(1) == 1) str_buf[0] = CH_PREFIX0;
         end else if (kind < 90) begin
            // good prefix, ends in the header or before a whole group
            str_buf = '{CH_PREFIX0, CH_PREFIX1};
            n = $urandom_range(0, HDR_SKIP + 3);
            repeat (n) str_buf.push_back(sym_char($urandom_range(63)));
         end else begin
            // plain noise
            str_buf.delete();
            n = $urandom_range(1, 24);
            repeat (n) str_buf.push_back(8'($urandom_range(1, 255)));
         end
         send_buf();
         nstr++;
      end

      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (8) @(posedge clock);

      $display("decoded %0d strings from %0d characters: %0d byte beats, %0d status beats",
               strings_sent, items_sent, data_beats, status_beats);
      $display("included random gaps on both sides, a %0d-cycle receiver hold-off and a drain pause",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/nscb64_pkg.sv
rtl/nscb64_step.sv
rtl/nsc_base64_decoder.sv
tb/decode_checker.sv
tb/tb.sv
